// ===== design/tcfo_pkg.sv =====
// ----------------------------------------------------------------------------
// tcfo_pkg
// Shared types, constants and helpers for the two-class oldest-first FIFO.
// ----------------------------------------------------------------------------
package tcfo_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_BITS    = 32;
  localparam int STAMP_BITS  = 32;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W     = STAMP_BITS + TAG_BITS;

  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [STAMP_BITS-1:0] stamp_t;
  typedef logic [TAG_BITS-1:0]   tag_t;

  typedef enum logic [2:0] {
    CMD_ENQ_A   = 3'd0,
    CMD_ENQ_B   = 3'd1,
    CMD_DEQ_A   = 3'd2,
    CMD_DEQ_B   = 3'd3,
    CMD_DEQ_OLD = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_ENQUEUED = 2'd0,
    STAT_DEQUEUED = 2'd1,
    STAT_NONE     = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    CLASS_A = 1'b0,
    CLASS_B = 1'b1
  } class_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // per-class pointer update request
  typedef struct packed {
    logic push;
    logic pop;
  } qctl_t;

  // per-class pointer state
  typedef struct packed {
    ptr_t head;
    ptr_t tail;
    cnt_t count;
  } qstat_t;

  function automatic ptr_t next_slot(input ptr_t p);
    if (p == ptr_t'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + ptr_t'(1);
  endfunction

endpackage

// ===== design/two_class_fifo_oldest_first.sv =====
// ----------------------------------------------------------------------------
// two_class_fifo_oldest_first
// Two class queues with a shared arrival stamp and oldest-first dequeue.
// ----------------------------------------------------------------------------
// Each request has an accept and an execute cycle: in the accept cycle both
// queue heads are read from their RAMs (registered read), in the execute cycle
// the result is formed, the RAM is written on enqueue and the pointers move.
// The limit is the head read of the synchronous store, so one request is in
// flight at a time and cmd_stall is high during the execute cycle. The result
// sits in an output register; a new request is taken while a result waits, and
// the execute cycle holds until that register frees up. Enqueue stamps
// counter+1 (wrapping at 2^32); a full queue reports queue-full and drops the
// item without advancing the counter. Dequeue-oldest compares head stamps as
// unsigned numbers, takes class B on a tie, and flags fell_back when only one
// class holds items. Stores are not cleared at reset; empty slots go unused.
// ----------------------------------------------------------------------------
module two_class_fifo_oldest_first (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [2:0]  command,
  input  logic [31:0] item_tag,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  status,
  output logic        item_class,
  output logic [31:0] out_tag,
  output logic [31:0] arrival_number,
  output logic        fell_back
);

  tcfo_pkg::state_t state;
  tcfo_pkg::state_t state_next;

  logic [2:0]         cmd_r;
  tcfo_pkg::tag_t     tag_r;
  tcfo_pkg::stamp_t   arrival_counter;

  tcfo_pkg::qctl_t    ctl_a, ctl_b;
  tcfo_pkg::qstat_t   stat_a, stat_b;

  logic [tcfo_pkg::ENTRY_W-1:0] rd_a, rd_b, wdata;
  logic               we_a, we_b;

  logic               accept;
  logic               fire;

  // execute-cycle decisions
  logic               a_has, b_has;
  tcfo_pkg::stamp_t   stamp_a, stamp_b;
  logic               do_push, do_pop, full, push_cls, pop_cls;
  logic               fb;
  tcfo_pkg::status_t  r_status;
  logic               r_class;
  tcfo_pkg::tag_t     r_tag;
  tcfo_pkg::stamp_t   r_stamp;
  tcfo_pkg::stamp_t   new_stamp;

  assign cmd_stall = (state != tcfo_pkg::ST_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign fire      = (state == tcfo_pkg::ST_EXEC) && (!res_valid || !res_stall);

  // ---- request capture ----
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= command;
      tag_r <= item_tag[tcfo_pkg::TAG_BITS-1:0];
    end
  end

  // ---- state register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcfo_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tcfo_pkg::ST_IDLE: if (accept) state_next = tcfo_pkg::ST_EXEC;
      tcfo_pkg::ST_EXEC: if (fire) state_next = tcfo_pkg::ST_IDLE;
      default:           state_next = tcfo_pkg::ST_IDLE;
    endcase
  end

  // ---- stores: heads read on accept, data held through the execute cycle ----
  tcfo_ram #(.WIDTH(tcfo_pkg::ENTRY_W), .DEPTH(tcfo_pkg::QUEUE_DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (stat_a.tail),
    .wdata (wdata),
    .re    (accept),
    .raddr (stat_a.head),
    .rdata (rd_a)
  );

  tcfo_ram #(.WIDTH(tcfo_pkg::ENTRY_W), .DEPTH(tcfo_pkg::QUEUE_DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (stat_b.tail),
    .wdata (wdata),
    .re    (accept),
    .raddr (stat_b.head),
    .rdata (rd_b)
  );

  tcfo_ptrs u_ptrs_a (.clk(clk), .rst(rst), .ctl(ctl_a), .stat(stat_a));
  tcfo_ptrs u_ptrs_b (.clk(clk), .rst(rst), .ctl(ctl_b), .stat(stat_b));

  // ---- execute: decide the request ----
  assign a_has     = (stat_a.count != '0);
  assign b_has     = (stat_b.count != '0);
  assign stamp_a   = rd_a[tcfo_pkg::ENTRY_W-1:tcfo_pkg::TAG_BITS];
  assign stamp_b   = rd_b[tcfo_pkg::ENTRY_W-1:tcfo_pkg::TAG_BITS];
  assign new_stamp = arrival_counter + tcfo_pkg::stamp_t'(1);

  always_comb begin
    do_push  = 1'b0;
    do_pop   = 1'b0;
    push_cls = tcfo_pkg::CLASS_A;
    pop_cls  = tcfo_pkg::CLASS_A;
    fb       = 1'b0;
    full     = 1'b0;
    r_status = tcfo_pkg::STAT_NONE;
    r_class  = tcfo_pkg::CLASS_A;
    r_tag    = '0;
    r_stamp  = '0;

    case (cmd_r)
      tcfo_pkg::CMD_ENQ_A, tcfo_pkg::CMD_ENQ_B: begin
        push_cls = (cmd_r == tcfo_pkg::CMD_ENQ_B);
        r_class  = push_cls;
        full     = push_cls ?
                   (stat_b.count == tcfo_pkg::cnt_t'(tcfo_pkg::QUEUE_DEPTH)) :
                   (stat_a.count == tcfo_pkg::cnt_t'(tcfo_pkg::QUEUE_DEPTH));
        if (full) begin
          r_status = tcfo_pkg::STAT_FULL;
        end else begin
          do_push  = 1'b1;
          r_status = tcfo_pkg::STAT_ENQUEUED;
          r_stamp  = new_stamp;
        end
      end
      tcfo_pkg::CMD_DEQ_A: begin
        pop_cls = tcfo_pkg::CLASS_A;
        r_class = tcfo_pkg::CLASS_A;
        do_pop  = a_has;
      end
      tcfo_pkg::CMD_DEQ_B: begin
        pop_cls = tcfo_pkg::CLASS_B;
        r_class = tcfo_pkg::CLASS_B;
        do_pop  = b_has;
      end
      tcfo_pkg::CMD_DEQ_OLD: begin
        if (a_has && b_has) begin
          // tie goes to class B
          do_pop  = 1'b1;
          pop_cls = (stamp_a < stamp_b) ? tcfo_pkg::CLASS_A : tcfo_pkg::CLASS_B;
        end else if (a_has || b_has) begin
          do_pop  = 1'b1;
          pop_cls = b_has;
          fb      = 1'b1;
        end
        r_class = pop_cls;
      end
      default: ;
    endcase

    if (do_pop) begin
      r_status = tcfo_pkg::STAT_DEQUEUED;
      r_tag    = pop_cls ? rd_b[tcfo_pkg::TAG_BITS-1:0] : rd_a[tcfo_pkg::TAG_BITS-1:0];
      r_stamp  = pop_cls ? stamp_b : stamp_a;
    end
  end

  // ---- pointer and store updates, only when the result can be posted ----
  assign ctl_a.push = fire && do_push && (push_cls == tcfo_pkg::CLASS_A);
  assign ctl_b.push = fire && do_push && (push_cls == tcfo_pkg::CLASS_B);
  assign ctl_a.pop  = fire && do_pop  && (pop_cls  == tcfo_pkg::CLASS_A);
  assign ctl_b.pop  = fire && do_pop  && (pop_cls  == tcfo_pkg::CLASS_B);
  assign we_a       = ctl_a.push;
  assign we_b       = ctl_b.push;
  assign wdata      = {new_stamp, tag_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      arrival_counter <= '0;
    end else if (fire && do_push) begin
      arrival_counter <= new_stamp;
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status         <= r_status;
      item_class     <= r_class;
      out_tag        <= 32'(r_tag);
      arrival_number <= r_stamp;
      fell_back      <= fb;
    end
  end

endmodule

// ===== design/tcfo_ram.sv =====
// ----------------------------------------------------------------------------
// tcfo_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcfo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/tcfo_ptrs.sv =====
// ----------------------------------------------------------------------------
// tcfo_ptrs
// Head, tail and occupancy count of one class queue.
// ----------------------------------------------------------------------------
module tcfo_ptrs (
  input  logic           clk,
  input  logic           rst,
  input  tcfo_pkg::qctl_t  ctl,
  output tcfo_pkg::qstat_t stat
);

  tcfo_pkg::ptr_t head;
  tcfo_pkg::ptr_t tail;
  tcfo_pkg::cnt_t count;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (ctl.push) begin
        tail  <= tcfo_pkg::next_slot(tail);
        count <= count + tcfo_pkg::cnt_t'(1);
      end else if (ctl.pop) begin
        head  <= tcfo_pkg::next_slot(head);
        count <= count - tcfo_pkg::cnt_t'(1);
      end
    end
  end

  assign stat.head  = head;
  assign stat.tail  = tail;
  assign stat.count = count;

  // push and pop never target one class in the same request
  a_no_push_pop: assert property (@(posedge clk) disable iff (rst)
    !(ctl.push && ctl.pop))
    else $error("push and pop together");

  // no push into a full queue, no pop from an empty one
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !((ctl.push && count == tcfo_pkg::cnt_t'(tcfo_pkg::QUEUE_DEPTH)) ||
      (ctl.pop && count == '0)))
    else $error("queue overrun or underrun");

  // a pop frees exactly one entry and moves the head
  a_pop_effect: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |=> (count == $past(count) - tcfo_pkg::cnt_t'(1)) && (head != $past(head) ||
      tcfo_pkg::QUEUE_DEPTH == 1))
    else $error("pop did not advance");

endmodule
